[rtl/core/quadrant_min_max_mean_stats_top_defines.svh]
// assertion macros for the quadrant statistics block
`ifndef QUADRANT_MIN_MAX_MEAN_STATS_TOP_DEFINES_SVH
`define QUADRANT_MIN_MAX_MEAN_STATS_TOP_DEFINES_SVH

// same-cycle implication
`define QMMS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define QMMS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/qmms_pkg.sv]
// shared types and constants of the quadrant statistics block
`timescale 1ns / 1ps
`default_nettype none
package qmms_pkg;

	localparam int MAX_WIDTH_DEF  = 4096;
	localparam int MAX_HEIGHT_DEF = 4096;
	localparam int PIX_W          = 8;
	localparam int CFG_W          = 13;
	localparam int DIM_MIN        = 2;
	localparam int NUM_REGIONS    = 4;
	localparam int FIFO_DEPTH     = 4;
	localparam int SUM_W_DEF      = PIX_W + $clog2(MAX_WIDTH_DEF) + $clog2(MAX_HEIGHT_DEF);

	localparam logic [PIX_W-1:0] LEVEL_MAX = '1;

	localparam logic [1:0]       BIN_SHIFT_RST  = 2'd0;
	localparam logic             WHOLE_MODE_RST = 1'b1;
	localparam logic [CFG_W-1:0] WIDTH_RST      = 13'd640;
	localparam logic [CFG_W-1:0] HEIGHT_RST     = 13'd480;

	typedef enum logic [1:0] {
		CFG_BIN_SHIFT    = 2'd0,
		CFG_WHOLE_MODE   = 2'd1,
		CFG_FRAME_WIDTH  = 2'd2,
		CFG_FRAME_HEIGHT = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		RPT_IDLE,
		RPT_LOAD,
		RPT_DIV,
		RPT_OUT
	} rpt_state_t;

	typedef struct packed {
		logic [PIX_W-1:0] level;
		logic [1:0]       quad;
		logic             frame_end;
	} pix_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_status_t;

endpackage
`default_nettype wire

[rtl/core/qmms_front.sv]
// front end: pixel intake, requantization, quadrant and frame-end tagging
`timescale 1ns / 1ps
`default_nettype none
module qmms_front import qmms_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [PIX_W-1:0]                  pixel,
	input  wire logic [1:0]                        bin_shift,
	input  wire logic [$clog2(MAX_WIDTH+1)-1:0]    width_eff,
	input  wire logic [$clog2(MAX_HEIGHT+1)-1:0]   height_eff,
	input  wire fifo_status_t                      fifo_stat,
	output logic                                   push,
	output pix_item_t                              push_item
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);
	localparam int WD_W  = $clog2(MAX_WIDTH + 1);
	localparam int HD_W  = $clog2(MAX_HEIGHT + 1);

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [WD_W-1:0]  col_ext, col_inc;
	logic [HD_W-1:0]  row_ext, row_inc;
	logic             row_end, frame_end;

	always_comb begin
		col_ext   = WD_W'(col_q);
		row_ext   = HD_W'(row_q);
		col_inc   = col_ext + WD_W'(1);
		row_inc   = row_ext + HD_W'(1);
		row_end   = (col_inc >= width_eff);
		frame_end = row_end && (row_inc >= height_eff);
		in_ready  = !fifo_stat.full;
		push      = in_valid && in_ready;
		push_item.level     = pixel >> bin_shift;
		push_item.quad      = {(row_ext >= (height_eff >> 1)), (col_ext >= (width_eff >> 1))};
		push_item.frame_end = frame_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (push) begin
			if (!row_end) begin
				col_q <= col_inc[COL_W-1:0];
			end else begin
				col_q <= '0;
				if (!frame_end) begin
					row_q <= row_inc[ROW_W-1:0];
				end else begin
					row_q <= '0;
				end
			end
		end
	end

endmodule
`default_nettype wire

[rtl/core/qmms_fifo.sv]
// short request queue between front end and accumulators
`timescale 1ns / 1ps
`default_nettype none
module qmms_fifo import qmms_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire pix_item_t push_item,
	input  wire logic      pop,
	output pix_item_t      head,
	output fifo_status_t   stat
);

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	pix_item_t        mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(FIFO_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + PTR_W'(1);
		end
		return r;
	endfunction

	always_comb begin
		head       = mem_q[rd_ptr_q];
		stat.full  = (count_q == CNT_W'(FIFO_DEPTH));
		stat.empty = (count_q == '0);
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

[rtl/core/qmms_accum.sv]
// back end: per-quadrant running min, max and sum
`timescale 1ns / 1ps
`default_nettype none
module qmms_accum import qmms_pkg::*; #(
	parameter int SUM_W = SUM_W_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire fifo_status_t     fifo_stat,
	input  wire pix_item_t        head,
	input  wire logic             rpt_busy,
	output logic                  pop,
	output logic                  rpt_start,
	output logic [PIX_W-1:0]      snap_min [NUM_REGIONS],
	output logic [PIX_W-1:0]      snap_max [NUM_REGIONS],
	output logic [SUM_W-1:0]      snap_sum [NUM_REGIONS]
);

	logic [PIX_W-1:0] min_q [NUM_REGIONS];
	logic [PIX_W-1:0] max_q [NUM_REGIONS];
	logic [SUM_W-1:0] sum_q [NUM_REGIONS];
	logic [PIX_W-1:0] new_min, new_max;
	logic [SUM_W-1:0] new_sum;

	always_comb begin
		// a frame-end request waits while the previous frame is still reported
		pop       = !fifo_stat.empty && (!head.frame_end || !rpt_busy);
		rpt_start = pop && head.frame_end;
		new_min   = (head.level < min_q[head.quad]) ? head.level : min_q[head.quad];
		new_max   = (head.level > max_q[head.quad]) ? head.level : max_q[head.quad];
		new_sum   = sum_q[head.quad] + SUM_W'(head.level);
		for (int k = 0; k < NUM_REGIONS; k++) begin
			if (head.quad == 2'(k)) begin
				snap_min[k] = new_min;
				snap_max[k] = new_max;
				snap_sum[k] = new_sum;
			end else begin
				snap_min[k] = min_q[k];
				snap_max[k] = max_q[k];
				snap_sum[k] = sum_q[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_REGIONS; k++) begin
				min_q[k] <= LEVEL_MAX;
				max_q[k] <= '0;
				sum_q[k] <= '0;
			end
		end else if (pop) begin
			if (head.frame_end) begin
				for (int k = 0; k < NUM_REGIONS; k++) begin
					min_q[k] <= LEVEL_MAX;
					max_q[k] <= '0;
					sum_q[k] <= '0;
				end
			end else begin
				min_q[head.quad] <= new_min;
				max_q[head.quad] <= new_max;
				sum_q[head.quad] <= new_sum;
			end
		end
	end

endmodule
`default_nettype wire

[rtl/core/qmms_report.sv]
// result sequencer: frame snapshot, serial mean divider, output register
`timescale 1ns / 1ps
`default_nettype none
module qmms_report import qmms_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
	parameter int SUM_W      = SUM_W_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            rpt_start,
	input  wire logic [PIX_W-1:0]                snap_min [NUM_REGIONS],
	input  wire logic [PIX_W-1:0]                snap_max [NUM_REGIONS],
	input  wire logic [SUM_W-1:0]                snap_sum [NUM_REGIONS],
	input  wire logic                            whole_mode,
	input  wire logic [$clog2(MAX_WIDTH+1)-1:0]  width_eff,
	input  wire logic [$clog2(MAX_HEIGHT+1)-1:0] height_eff,
	output logic                                 rpt_busy,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [1:0]                           region,
	output logic [PIX_W-1:0]                     min_level,
	output logic [PIX_W-1:0]                     max_level,
	output logic [PIX_W-1:0]                     mean_level,
	output logic                                 last_region
);

	localparam int WD_W   = $clog2(MAX_WIDTH + 1);
	localparam int HD_W   = $clog2(MAX_HEIGHT + 1);
	localparam int AREA_W = WD_W + HD_W;
	localparam int NUM_W  = SUM_W + 2;
	localparam int DIV_W  = (NUM_W > AREA_W + PIX_W) ? NUM_W : AREA_W + PIX_W;
	localparam int STEP_W = $clog2(PIX_W + 1);

	rpt_state_t        state_q, state_d;
	logic              whole_q;
	logic [PIX_W-1:0]  smin_q [NUM_REGIONS];
	logic [PIX_W-1:0]  smax_q [NUM_REGIONS];
	logic [SUM_W-1:0]  ssum_q [NUM_REGIONS];
	logic [AREA_W-1:0] area_q;
	logic [DIV_W-1:0]  rem_q, dvs_q, diff;
	logic [PIX_W-1:0]  quo_q;
	logic              sat_q, ge;
	logic [STEP_W-1:0] step_q;
	logic [1:0]        k_q;
	logic [PIX_W-1:0]  all_min, all_max, sel_min, sel_max;
	logic [NUM_W-1:0]  all_sum, numer;

	always_comb begin
		all_min = LEVEL_MAX;
		all_max = '0;
		all_sum = '0;
		for (int k = 0; k < NUM_REGIONS; k++) begin
			if (smin_q[k] < all_min) begin
				all_min = smin_q[k];
			end
			if (smax_q[k] > all_max) begin
				all_max = smax_q[k];
			end
			all_sum = all_sum + NUM_W'(ssum_q[k]);
		end
		// quadrant mean is scaled by four
		numer   = whole_q ? all_sum : {ssum_q[k_q], 2'b00};
		sel_min = whole_q ? all_min : smin_q[k_q];
		sel_max = whole_q ? all_max : smax_q[k_q];
		ge      = (rem_q >= dvs_q);
		diff    = rem_q - dvs_q;
	end

	always_comb begin
		state_d   = state_q;
		rpt_busy  = (state_q != RPT_IDLE);
		out_valid = 1'b0;
		case (state_q)
			RPT_IDLE: begin
				if (rpt_start) begin
					state_d = RPT_LOAD;
				end
			end
			RPT_LOAD: begin
				state_d = RPT_DIV;
			end
			RPT_DIV: begin
				if (step_q == '0) begin
					state_d = RPT_OUT;
				end
			end
			RPT_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = last_region ? RPT_IDLE : RPT_LOAD;
				end
			end
			default: begin
				state_d = RPT_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= RPT_IDLE;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == RPT_IDLE && rpt_start) begin
				k_q <= '0;
			end else if (state_q == RPT_OUT && out_ready && !last_region) begin
				k_q <= k_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			RPT_IDLE: begin
				if (rpt_start) begin
					whole_q <= whole_mode;
					area_q  <= AREA_W'(width_eff) * AREA_W'(height_eff);
					for (int k = 0; k < NUM_REGIONS; k++) begin
						smin_q[k] <= snap_min[k];
						smax_q[k] <= snap_max[k];
						ssum_q[k] <= snap_sum[k];
					end
				end
			end
			RPT_LOAD: begin
				rem_q       <= DIV_W'(numer);
				dvs_q       <= DIV_W'(area_q) << PIX_W;
				step_q      <= STEP_W'(PIX_W);
				quo_q       <= '0;
				sat_q       <= 1'b0;
				min_level   <= sel_min;
				max_level   <= sel_max;
				region      <= whole_q ? 2'd0 : k_q;
				last_region <= whole_q || (k_q == 2'(NUM_REGIONS - 1));
			end
			RPT_DIV: begin
				if (ge) begin
					rem_q <= diff;
				end
				dvs_q  <= dvs_q >> 1;
				step_q <= step_q - STEP_W'(1);
				// top trial step only flags saturation
				if (step_q == STEP_W'(PIX_W)) begin
					sat_q <= ge;
				end else begin
					quo_q <= {quo_q[PIX_W-2:0], ge};
				end
				if (step_q == '0) begin
					mean_level <= sat_q ? LEVEL_MAX : {quo_q[PIX_W-2:0], ge};
				end
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

[rtl/core/quadrant_min_max_mean_stats_top.sv]
// top level of the quadrant min/max/mean statistics block
//
//  channel  | direction | signals                                         | moves
//  ---------+-----------+-------------------------------------------------+---------------
//  cfg      | in        | cfg_valid cfg_ready cfg_index cfg_data          | register write
//  in       | in        | in_valid in_ready pixel                         | one pixel
//  out      | out       | out_valid out_ready region min/max/mean_level   | one region
//           |           | last_region                                     | result
//
//  mid-frame pixels: one per cycle while the queue has room, set by the accumulator read-modify-write per request
//  frame end: area multiply at the snapshot, then per result a load, 9 divider steps and an
//  output state held until out_ready; next-frame pixels keep flowing until the next frame-end request
//  reset: config to defaults, counters, queue and statistics cleared at once
//  stalls: a 4-deep queue separates intake from accumulation; out_ready low holds the result
`timescale 1ns / 1ps
`default_nettype none
module quadrant_min_max_mean_stats_top import qmms_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [PIX_W-1:0] pixel,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [1:0]            region,
	output logic [PIX_W-1:0]      min_level,
	output logic [PIX_W-1:0]      max_level,
	output logic [PIX_W-1:0]      mean_level,
	output logic                  last_region
);

	localparam int WD_W  = $clog2(MAX_WIDTH + 1);
	localparam int HD_W  = $clog2(MAX_HEIGHT + 1);
	localparam int SUM_W = PIX_W + $clog2(MAX_WIDTH) + $clog2(MAX_HEIGHT);

	logic [1:0]       bin_shift_q;
	logic             whole_mode_q;
	logic [CFG_W-1:0] width_q, height_q;
	logic [WD_W-1:0]  width_eff;
	logic [HD_W-1:0]  height_eff;

	fifo_status_t     fifo_stat;
	pix_item_t        push_item, head;
	logic             push, pop, rpt_start, rpt_busy;
	logic [PIX_W-1:0] snap_min [NUM_REGIONS];
	logic [PIX_W-1:0] snap_max [NUM_REGIONS];
	logic [SUM_W-1:0] snap_sum [NUM_REGIONS];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_shift_q  <= BIN_SHIFT_RST;
			whole_mode_q <= WHOLE_MODE_RST;
			width_q      <= WIDTH_RST;
			height_q     <= HEIGHT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_BIN_SHIFT:    bin_shift_q  <= cfg_data[1:0];
				CFG_WHOLE_MODE:   whole_mode_q <= cfg_data[0];
				CFG_FRAME_WIDTH:  width_q      <= cfg_data;
				CFG_FRAME_HEIGHT: height_q     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// clamp dimensions to the supported range
	always_comb begin
		if (width_q < CFG_W'(DIM_MIN)) begin
			width_eff = WD_W'(DIM_MIN);
		end else if (width_q > CFG_W'(MAX_WIDTH)) begin
			width_eff = WD_W'(MAX_WIDTH);
		end else begin
			width_eff = WD_W'(width_q);
		end
		if (height_q < CFG_W'(DIM_MIN)) begin
			height_eff = HD_W'(DIM_MIN);
		end else if (height_q > CFG_W'(MAX_HEIGHT)) begin
			height_eff = HD_W'(MAX_HEIGHT);
		end else begin
			height_eff = HD_W'(height_q);
		end
	end

	qmms_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.pixel      (pixel),
		.bin_shift  (bin_shift_q),
		.width_eff  (width_eff),
		.height_eff (height_eff),
		.fifo_stat  (fifo_stat),
		.push       (push),
		.push_item  (push_item)
	);

	qmms_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.stat      (fifo_stat)
	);

	qmms_accum #(
		.SUM_W (SUM_W)
	) u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.fifo_stat (fifo_stat),
		.head      (head),
		.rpt_busy  (rpt_busy),
		.pop       (pop),
		.rpt_start (rpt_start),
		.snap_min  (snap_min),
		.snap_max  (snap_max),
		.snap_sum  (snap_sum)
	);

	qmms_report #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.SUM_W      (SUM_W)
	) u_report (
		.clk         (clk),
		.arst_n      (arst_n),
		.rpt_start   (rpt_start),
		.snap_min    (snap_min),
		.snap_max    (snap_max),
		.snap_sum    (snap_sum),
		.whole_mode  (whole_mode_q),
		.width_eff   (width_eff),
		.height_eff  (height_eff),
		.rpt_busy    (rpt_busy),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.region      (region),
		.min_level   (min_level),
		.max_level   (max_level),
		.mean_level  (mean_level),
		.last_region (last_region)
	);

endmodule
`default_nettype wire

[rtl/core/qmms_checker.sv]
// port-level assertions for the quadrant statistics block, with bind
`timescale 1ns / 1ps
`default_nettype none
`include "quadrant_min_max_mean_stats_top_defines.svh"
module qmms_checker import qmms_pkg::*; (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             in_valid,
	input wire logic             in_ready,
	input wire logic [PIX_W-1:0] pixel,
	input wire logic             out_valid,
	input wire logic             out_ready,
	input wire logic [1:0]       region,
	input wire logic [PIX_W-1:0] min_level,
	input wire logic [PIX_W-1:0] max_level,
	input wire logic [PIX_W-1:0] mean_level,
	input wire logic             last_region
);

	`QMMS_ASSERT_NEXT(a_in_hold, clk, arst_n, in_valid && !in_ready, in_valid && $stable(pixel), "pixel request changed while waiting")
	`QMMS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(region) && $stable(min_level) && $stable(max_level) && $stable(mean_level) && $stable(last_region), "result changed while stalled")
	`QMMS_ASSERT_SAME(a_last_region, clk, arst_n, out_valid && last_region, (region == 2'd0) || (region == 2'd3), "frame ended on a middle quadrant")
	`QMMS_ASSERT_SAME(a_not_last, clk, arst_n, out_valid && !last_region, region != 2'd3, "bottom-right quadrant not marked last")
	`QMMS_ASSERT_NEXT(a_gap, clk, arst_n, out_valid && out_ready && !last_region, !out_valid, "next quadrant result shown without a divide pass")

endmodule

bind quadrant_min_max_mean_stats_top qmms_checker u_qmms_checker (.*);
`default_nettype wire
